// File: sv/glob_wildcard_matcher_defines.svh
// Assertion macros for the glob wildcard matcher checker.
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define GWM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gwm: same-cycle check failed");

// Condition implies consequence in the following cycle.
`define GWM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gwm: next-cycle check failed");

`endif

// File: sv/gwm_pkg.sv
// Types, constants and helper functions for the glob wildcard matcher.
`timescale 1ns / 1ps

package gwm_pkg;

  // Characters carried by the configuration registers.
  localparam int REG_CHARS = 16;
  // Width of the mask length register.
  localparam int LEN_W = 5;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QUEST_CHAR = 8'h3F;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MASK_LOW  = 2'd0,
    CFG_MASK_HIGH = 2'd1,
    CFG_MASK_LEN  = 2'd2
  } cfg_index_t;

  // Fold ASCII upper case to lower case; other bytes pass unchanged.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: sv/gwm_step.sv
// Next-position logic: one subject character advances all mask positions.
`timescale 1ns / 1ps

module gwm_step #(
  parameter int N = 16
) (
  input  logic [63:0]              mask_low,
  input  logic [63:0]              mask_high,
  input  logic [gwm_pkg::LEN_W-1:0] mask_length,
  input  logic [7:0]               character,
  input  logic [N:0]               current,
  output logic [N:0]               start_positions,
  output logic [N:0]               next_positions,
  output logic                     whole_match
);

  localparam int LIMIT = (N < gwm_pkg::REG_CHARS) ? N : gwm_pkg::REG_CHARS;

  logic [gwm_pkg::LEN_W-1:0] eff_len;
  logic [N-1:0][7:0]         chars;
  logic [N-1:0]              star;
  logic [N-1:0]              adv;
  logic [N:0]                raw;
  logic [7:0]                folded_char;

  // Saturate the length to what both the registers and the vector can hold.
  assign eff_len = (mask_length > gwm_pkg::LEN_W'(LIMIT)) ?
                   gwm_pkg::LEN_W'(LIMIT) : mask_length;
  assign folded_char = gwm_pkg::fold(character);

  // Mask characters per position; positions past the registers read as zero.
  for (genvar g = 0; g < N; g++) begin : g_chars
    if (g < 8) begin : g_low
      assign chars[g] = mask_low[8*g +: 8];
    end else if (g < gwm_pkg::REG_CHARS) begin : g_high
      assign chars[g] = mask_high[8*(g-8) +: 8];
    end else begin : g_none
      assign chars[g] = 8'h00;
    end
  end

  // Classify each position in use as star, or as matching this character.
  always_comb begin
    logic en;
    for (int i = 0; i < N; i++) begin
      en = (7'(i) < 7'(eff_len));
      star[i] = en && (chars[i] == gwm_pkg::STAR_CHAR);
      adv[i]  = en && (chars[i] != gwm_pkg::STAR_CHAR) &&
                ((chars[i] == gwm_pkg::QUEST_CHAR) ||
                 (gwm_pkg::fold(chars[i]) == folded_char));
    end
  end

  // A star keeps its position; a matching position moves one ahead.
  always_comb begin
    raw = '0;
    for (int i = 0; i < N; i++) begin
      raw[i]   = raw[i] | (current[i] & star[i]);
      raw[i+1] = current[i] & adv[i];
    end
  end

  // Close the new vector over stars, lowest position first.
  always_comb begin
    next_positions[0] = raw[0];
    for (int i = 0; i < N; i++) begin
      next_positions[i+1] = raw[i+1] | (next_positions[i] & star[i]);
    end
  end

  // Vector for a fresh string: position zero, closed over leading stars.
  always_comb begin
    start_positions[0] = 1'b1;
    for (int i = 0; i < N; i++) begin
      start_positions[i+1] = start_positions[i] & star[i];
    end
  end

  // The string matches when the final position is active.
  always_comb begin
    whole_match = 1'b0;
    for (int i = 0; i <= N; i++) begin
      whole_match = whole_match | (current[i] && (7'(i) == 7'(eff_len)));
    end
  end

endmodule

// File: sv/glob_wildcard_matcher.sv
// Top level of the streaming glob wildcard matcher.
//
//  Channel   Direction  Signals                          Content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser subject characters and end marks
//  m_*       out        m_tvalid m_tready m_tdata        one match flag per string
//  cfg_*     in         cfg_valid cfg_ready cfg_index    mask registers
//                       cfg_data
//
// One item enters per cycle while the input register can move on. An accepted
// item waits in the input register; the position update and the result register
// are written when it moves on, so a result is registered behind its end item.
// Reset clears the mask to empty and restarts the position vector.
// A stalled result holds back an end item in the input register and the items behind it.
`timescale 1ns / 1ps

module glob_wildcard_matcher #(
  parameter int MASK_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Subject stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tuser,   // [0] kind (1 = end of string)
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] matched, [7:1] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]               mask_low;
  logic [63:0]               mask_high;
  logic [gwm_pkg::LEN_W-1:0] mask_length;
  logic                      fresh;
  logic [MASK_CHARS:0]       active;
  logic                      p_valid;
  logic                      p_kind;
  logic [7:0]                p_char;
  logic                      out_valid;
  logic                      out_matched;

  logic                      p_go;
  logic                      s_take;
  logic [MASK_CHARS:0]       cur;
  logic [MASK_CHARS:0]       start_positions;
  logic [MASK_CHARS:0]       next_positions;
  logic                      whole_match;

  // The input register moves on unless an end item meets a full result register that is not read.
  assign p_go      = p_valid && (!p_kind || !out_valid || m_tready);
  assign s_tready  = !p_valid || p_go;
  assign s_take    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'b0, out_matched};

  // After a restart the vector is the start vector of the current mask.
  assign cur = fresh ? start_positions : active;

  gwm_step #(
    .N (MASK_CHARS)
  ) u_step (
    .mask_low        (mask_low),
    .mask_high       (mask_high),
    .mask_length     (mask_length),
    .character       (p_char),
    .current         (cur),
    .start_positions (start_positions),
    .next_positions  (next_positions),
    .whole_match     (whole_match)
  );

  // Input register payload.
  always_ff @(posedge clk) begin
    if (s_take) begin
      p_kind <= s_tuser;
      p_char <= s_tdata;
    end
  end

  // Active position vector, payload only; fresh marks it as stale.
  always_ff @(posedge clk) begin
    if (p_go && !p_kind) begin
      active <= next_positions;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (p_go && p_kind) begin
      out_matched <= whole_match;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_low    <= '0;
      mask_high   <= '0;
      mask_length <= '0;
      fresh       <= 1'b1;
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Input register occupancy.
      if (s_take) begin
        p_valid <= 1'b1;
      end else if (p_go) begin
        p_valid <= 1'b0;
      end

      // Result register occupancy.
      if (p_go && p_kind) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      // A register write restarts the vector for the new mask; otherwise a
      // character leaves a live vector and an end item restarts it.
      if (cfg_valid && (cfg_index == gwm_pkg::CFG_MASK_LOW ||
                        cfg_index == gwm_pkg::CFG_MASK_HIGH ||
                        cfg_index == gwm_pkg::CFG_MASK_LEN)) begin
        fresh <= 1'b1;
      end else if (p_go) begin
        fresh <= p_kind;
      end

      // Mask register writes.
      if (cfg_valid) begin
        case (cfg_index)
          gwm_pkg::CFG_MASK_LOW: begin
            mask_low <= cfg_data;
          end
          gwm_pkg::CFG_MASK_HIGH: begin
            mask_high <= cfg_data;
          end
          gwm_pkg::CFG_MASK_LEN: begin
            mask_length <= cfg_data[gwm_pkg::LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: sv/gwm_checker.sv
// Port-level checks for the glob wildcard matcher, bound to the top level.
`timescale 1ns / 1ps
`include "glob_wildcard_matcher_defines.svh"

module gwm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       cfg_ready
);

  // A stalled result keeps its flag.
  `GWM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The padding above the flag is always zero.
  `GWM_ASSERT_NOW(a_out_pad, clk, rst, m_tvalid, m_tdata[7:1] == 7'b0)

  // With no result waiting the input side never blocks.
  `GWM_ASSERT_NOW(a_in_open, clk, rst, !m_tvalid, s_tready)

  // Configuration writes are always taken.
  `GWM_ASSERT_NOW(a_cfg_open, clk, rst, 1'b1, cfg_ready)

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);
